// File: design/ftpe_pkg.sv
// Shared types, coefficient tables and fixed-point helpers for the trig polynomial unit.
package ftpe_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int MODE_W            = 3;
	localparam int ANGLE_W           = 19;
	localparam int VALUE_W           = 32;
	localparam int MODE_COUNT        = 6;
	localparam int MODE_SLOTS        = 1 << MODE_W;
	localparam int TERMS             = 7;
	localparam int HORNER_CELLS      = TERMS - 1;

	typedef enum logic [MODE_W-1:0] {
		MODE_SIN_SHORT = 3'd0,
		MODE_SIN_LONG  = 3'd1,
		MODE_COS_SHORT = 3'd2,
		MODE_COS_LONG  = 3'd3,
		MODE_TAN_SHORT = 3'd4,
		MODE_TAN_LONG  = 3'd5
	} mode_t;

	// Coefficients scaled by 1e10, highest power first, padded with leading zeros
	// so every mode runs the same number of Horner steps; last term is one.
	localparam longint unsigned COEF_DEN  = 64'd10000000000;
	localparam longint          ONE_SCALD = 64'sd10000000000;

	localparam longint POLY_TAB [MODE_COUNT][TERMS] = '{
		'{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd76100000, -64'sd1660500000, ONE_SCALD},
		'{64'sd0, -64'sd239, 64'sd27526, -64'sd1984090, 64'sd83333315,
			-64'sd1666666664, ONE_SCALD},
		'{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd370500000, -64'sd4967000000, ONE_SCALD},
		'{64'sd0, -64'sd2605, 64'sd247609, -64'sd13888397, 64'sd416666418,
			-64'sd4999999963, ONE_SCALD},
		'{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd2033000000, 64'sd3175500000, ONE_SCALD},
		'{64'sd95168091, 64'sd29005250, 64'sd245650893, 64'sd533740603,
			64'sd1333923995, 64'sd3333314036, ONE_SCALD}
	};

	typedef struct packed {
		logic [MODE_W-1:0]          mode;
		logic signed [ANGLE_W-1:0]  angle;
		logic signed [VALUE_W-1:0]  sq;
		logic signed [VALUE_W-1:0]  acc;
	} beat_t;

	// Round to nearest, ties away from zero, then apply sign and wrap to 32 bits.
	function automatic logic [VALUE_W-1:0] coef_fixed(int frac, longint scaled);
		logic [63:0]        mag;
		logic [63:0]        r;
		logic [VALUE_W-1:0] v;
		mag = (scaled < 0) ? 64'(-scaled) : 64'(scaled);
		r   = ((mag << frac) + COEF_DEN / 2) / COEF_DEN;
		v   = r[VALUE_W-1:0];
		return (scaled < 0) ? -v : v;
	endfunction

	// One coefficient column across all mode codes; unused codes read zero.
	function automatic logic [MODE_SLOTS-1:0][VALUE_W-1:0] coef_col(int frac, int idx);
		logic [MODE_SLOTS-1:0][VALUE_W-1:0] col;
		col = '0;
		for (int m = 0; m < MODE_COUNT; m++) begin
			col[m] = coef_fixed(frac, POLY_TAB[m][idx]);
		end
		return col;
	endfunction

	function automatic logic signed [VALUE_W-1:0] fx_mul(logic signed [VALUE_W-1:0] a,
			logic signed [VALUE_W-1:0] b, int frac);
		logic signed [2*VALUE_W-1:0] p;
		p = (2*VALUE_W)'(a) * (2*VALUE_W)'(b);
		p = p >>> frac;
		return p[VALUE_W-1:0];
	endfunction

	function automatic logic signed [VALUE_W-1:0] ext_angle(logic signed [ANGLE_W-1:0] a);
		return {{(VALUE_W-ANGLE_W){a[ANGLE_W-1]}}, a};
	endfunction

endpackage

// File: design/ftpe_front.sv
// Entry cell: squares the angle and loads the leading coefficient.
module ftpe_front #(
	parameter int FRACTION_BITS = ftpe_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ftpe_pkg::MODE_W-1:0]          mode,
	input  logic signed [ftpe_pkg::ANGLE_W-1:0]  angle,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output ftpe_pkg::beat_t                      out_beat
);

	localparam logic [ftpe_pkg::MODE_SLOTS-1:0][ftpe_pkg::VALUE_W-1:0] COEF =
		ftpe_pkg::coef_col(FRACTION_BITS, 0);

	logic                    valid_s1;
	ftpe_pkg::beat_t         beat_s1;
	ftpe_pkg::beat_t         beat_d;
	logic signed [ftpe_pkg::VALUE_W-1:0] ang_w;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		ang_w        = ftpe_pkg::ext_angle(angle);
		beat_d.mode  = mode;
		beat_d.angle = angle;
		beat_d.sq    = ftpe_pkg::fx_mul(ang_w, ang_w, FRACTION_BITS);
		beat_d.acc   = COEF[mode];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= beat_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_beat  = beat_s1;

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_ready |=> valid_s1 && $stable(beat_s1))
		else $error("front cell dropped or changed a stalled beat");

endmodule

// File: design/ftpe_horner_cell.sv
// One Horner step: acc <= acc * sq + coefficient, handed to the next cell.
module ftpe_horner_cell #(
	parameter int FRACTION_BITS = ftpe_pkg::FRACTION_BITS_DEF,
	parameter int IDX           = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ftpe_pkg::beat_t  in_beat,
	output logic             out_valid,
	input  logic             out_ready,
	output ftpe_pkg::beat_t  out_beat
);

	localparam logic [ftpe_pkg::MODE_SLOTS-1:0][ftpe_pkg::VALUE_W-1:0] COEF =
		ftpe_pkg::coef_col(FRACTION_BITS, IDX);

	logic            valid_q;
	ftpe_pkg::beat_t beat_q;
	ftpe_pkg::beat_t beat_d;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		beat_d     = in_beat;
		beat_d.acc = ftpe_pkg::fx_mul(in_beat.acc, in_beat.sq, FRACTION_BITS)
			+ COEF[in_beat.mode];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_q <= beat_d;
		end
	end

	assign out_valid = valid_q;
	assign out_beat  = beat_q;

	a_cell_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(beat_q))
		else $error("Horner cell dropped or changed a stalled beat");

endmodule

// File: design/ftpe_finish.sv
// Exit cell: multiplies odd functions by the angle, zeroes unused modes, holds the result.
module ftpe_finish #(
	parameter int FRACTION_BITS = ftpe_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ftpe_pkg::beat_t                     in_beat,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ftpe_pkg::VALUE_W-1:0] value
);

	logic                                valid_q;
	logic signed [ftpe_pkg::VALUE_W-1:0] value_q;
	logic signed [ftpe_pkg::VALUE_W-1:0] value_d;
	ftpe_pkg::mode_t                     md;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		md = ftpe_pkg::mode_t'(in_beat.mode);
		if (md inside {ftpe_pkg::MODE_SIN_SHORT, ftpe_pkg::MODE_SIN_LONG,
				ftpe_pkg::MODE_TAN_SHORT, ftpe_pkg::MODE_TAN_LONG}) begin
			value_d = ftpe_pkg::fx_mul(in_beat.acc, ftpe_pkg::ext_angle(in_beat.angle),
				FRACTION_BITS);
		end else if (md inside {ftpe_pkg::MODE_COS_SHORT, ftpe_pkg::MODE_COS_LONG}) begin
			value_d = in_beat.acc;
		end else begin
			value_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			value_q <= value_d;
		end
	end

	assign out_valid = valid_q;
	assign value     = value_q;

	a_fin_origin: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !$past(valid_q) |-> $past(in_valid))
		else $error("result appeared without an incoming beat");

endmodule

// File: design/fixed_trig_polynomial_eval_unit.sv
// Top level of the fixed-point sine / cosine / tangent polynomial unit.
//
// Input channel (in_valid / in_ready) carries mode and a signed Q angle;
// output channel (out_valid / out_ready) carries the signed result value.
// Modes 0..5 select sine, cosine or tangent, short or long polynomial;
// codes 6 and 7 return zero.
// The datapath is a row of eight cells: an entry cell that squares the
// angle, six Horner cells (one multiply-add each) and an exit cell that
// applies the final multiply by the angle. Every cell has one registered
// stage, and a beat is registered in each cell in turn, entry cell first.
// Throughput is one beat per cycle while the receiver keeps out_ready high; each cell owns one 32x32 multiplier.
// Each cell is ready when it is empty or its neighbor takes its beat, so
// bubbles close up and in_ready drops only once the whole row is full and
// the receiver holds off out_ready.
// Reset (arst_n low) empties all cells at once; no state survives a beat.
module fixed_trig_polynomial_eval_unit #(
	parameter int FRACTION_BITS = ftpe_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ftpe_pkg::MODE_W-1:0]          mode,
	input  logic signed [ftpe_pkg::ANGLE_W-1:0]  angle,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [ftpe_pkg::VALUE_W-1:0]  value
);

	localparam int N = ftpe_pkg::HORNER_CELLS;

	logic            chain_valid [N+1];
	logic            chain_ready [N+1];
	ftpe_pkg::beat_t chain_beat  [N+1];

	ftpe_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.angle     (angle),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_beat  (chain_beat[0])
	);

	for (genvar g = 0; g < N; g++) begin : g_cell
		ftpe_horner_cell #(.FRACTION_BITS(FRACTION_BITS), .IDX(g + 1)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[g]),
			.in_ready  (chain_ready[g]),
			.in_beat   (chain_beat[g]),
			.out_valid (chain_valid[g+1]),
			.out_ready (chain_ready[g+1]),
			.out_beat  (chain_beat[g+1])
		);
	end

	ftpe_finish #(.FRACTION_BITS(FRACTION_BITS)) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[N]),
		.in_ready  (chain_ready[N]),
		.in_beat   (chain_beat[N]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value)
	);

	// The row may only refuse a beat when it is full and the receiver stalls.
	a_top_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while the row could still advance");

	a_top_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> chain_ready[N])
		else $error("exit cell refused a beat while its result was taken");

endmodule
